@@ rtl/core/ckps_pkg.sv @@
// ckps_pkg: shared types and constants of the closest point selector
// used by the interfaces, the register block, controller, datapath and top level
`timescale 1ns / 1ps

package ckps_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;

  // fixed field widths
  localparam int MT_W      = 7;   // max_targets
  localparam int IDX_OUT_W = 6;   // target_index
  localparam int DIST_W    = 50;  // distance_sq
  localparam int SQ_IN_W   = 25;  // magnitudes at or above 2**25 saturate
  localparam int MAG_EXT_W = 33;  // widest axis magnitude over the coordinate range

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef logic [1:0] reg_code_t;
  localparam reg_code_t REG_MAX_TARGETS = 2'd0;
  localparam reg_code_t REG_ORIGIN_X    = 2'd1;
  localparam reg_code_t REG_ORIGIN_Y    = 2'd2;
  localparam reg_code_t REG_ORIGIN_Z    = 2'd3;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic {
    EMIT_READ,
    EMIT_BEST
  } emit_src_e;

  // controller to datapath
  typedef struct packed {
    logic      store;     // write accepted point, bump count or mark overflow
    logic      idx_clr;
    logic      idx_inc;
    logic      crd;       // read coordinates at idx
    logic      mag;       // axis magnitude stage
    axis_e     axis;
    logic      mul;       // square stage
    logic      acc_clr;   // load accumulator with square
    logic      acc;       // saturating accumulate
    logic      dwr;       // write distance at idx
    logic      drd;       // read distance at idx
    logic      scan;      // compare the distance fetched alongside it, once registered
    logic      best_clr;
    logic      emit;
    emit_src_e emit_sel;
    logic      emit_last;
    logic      clear;     // end of query, empty the set
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;   // idx points at the last stored point
    logic mode_all;   // max_targets covers the whole set
    logic want_zero;  // max_targets is zero
    logic k_last;     // this pick is the final one
    logic out_free;   // output register can take a result
  } status_t;

endpackage

@@ rtl/core/ckps_if.sv @@
// ckps_if: valid/ready channel interfaces for points and results
// depends on ckps_pkg for field widths
`timescale 1ns / 1ps

interface ckps_pt_if #(
  parameter int COORD_BITS = ckps_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         last_point;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output last_point, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input last_point, output ready);
endinterface

interface ckps_res_if ();
  import ckps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] target_index;
  logic [DIST_W-1:0]    distance_sq;
  logic                 last_target;
  logic                 overflow;

  modport source (output valid, output target_index, output distance_sq,
                  output last_target, output overflow, input ready);
  modport sink (input valid, input target_index, input distance_sq,
                input last_target, input overflow, output ready);
endinterface

@@ rtl/core/closest_k_point_select.sv @@
// closest_k_point_select: top level, joins config registers, controller and datapath
// depends on ckps_pkg, ckps_pt_if, ckps_res_if, ckps_regs, ckps_ctrl, ckps_datapath
//
// Usage: points arrive on point_i, one transfer per cycle while loading. Each is stored
// at the next load index; once MAX_POINTS are held further points are dropped and the
// overflow bit of the set is raised. A point with last_point closes the set.
// After it point_i.ready stays low for the whole query. With n points stored, a distance
// pass works through the points one by one (one shared 25x25 squarer, three axes in turn).
// If max_targets >= n every point is reported in load order.
// Otherwise max_targets points are reported nearest first, each found by a pass over the
// distance store at one read per cycle; max_targets of 0 gives none.
// Results sit in an output register on result_o; a stall there holds the sequencer
// before the next result. The final result carries last_target, and point_i opens
// again for the next set once that result is in the output register.
// Configuration registers must be written over the APB-style port only while no query runs;
// the block does not enforce this. Reset clears the set, the output register and the
// sequencer; max_targets resets to 1 and the origin to zero. No clearing pass follows reset.
`timescale 1ns / 1ps

module closest_k_point_select #(
  parameter int MAX_POINTS = ckps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = ckps_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckps_pkg::APB_AW-1:0] paddr,
  input  logic [ckps_pkg::APB_DW-1:0] pwdata,
  output logic [ckps_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  ckps_pt_if.sink                     point_i,
  ckps_res_if.source                  result_o
);
  import ckps_pkg::*;

  logic [MT_W-1:0]              max_targets;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  cmd_t                         cmd;
  status_t                      status;

  ckps_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_targets_o(max_targets),
    .origin_x_o   (origin_x),
    .origin_y_o   (origin_y),
    .origin_z_o   (origin_z)
  );

  ckps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_valid_i(point_i.valid),
    .pt_last_i (point_i.last_point),
    .pt_ready_o(point_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ckps_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .max_targets_i (max_targets),
    .origin_x_i    (origin_x),
    .origin_y_i    (origin_y),
    .origin_z_i    (origin_z),
    .pos_x_i       (point_i.pos_x),
    .pos_y_i       (point_i.pos_y),
    .pos_z_i       (point_i.pos_z),
    .res_valid_o   (result_o.valid),
    .res_ready_i   (result_o.ready),
    .res_index_o   (result_o.target_index),
    .res_dist_o    (result_o.distance_sq),
    .res_last_o    (result_o.last_target),
    .res_overflow_o(result_o.overflow)
  );

`ifndef SYNTHESIS
  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result issued while output register still full");

  // no result is issued in a cycle that takes a point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_i.valid && point_i.ready) |-> !cmd.emit)
    else $error("result issued during load");

  // the final result of a query reopens the point channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.emit_last) |=> point_i.ready)
    else $error("point channel not reopened after final result");
`endif

endmodule

@@ rtl/core/ckps_regs.sv @@
// ckps_regs: APB-style configuration registers (max_targets, query origin)
// depends on ckps_pkg for register codes and port widths
`timescale 1ns / 1ps

module ckps_regs #(
  parameter int COORD_BITS = ckps_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ckps_pkg::APB_AW-1:0]   paddr,
  input  logic [ckps_pkg::APB_DW-1:0]   pwdata,
  output logic [ckps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [ckps_pkg::MT_W-1:0]     max_targets_o,
  output logic signed [COORD_BITS-1:0]  origin_x_o,
  output logic signed [COORD_BITS-1:0]  origin_y_o,
  output logic signed [COORD_BITS-1:0]  origin_z_o
);
  import ckps_pkg::*;

  logic [MT_W-1:0]              max_targets_q;
  logic signed [COORD_BITS-1:0] origin_x_q;
  logic signed [COORD_BITS-1:0] origin_y_q;
  logic signed [COORD_BITS-1:0] origin_z_q;
  logic                         wr_en;
  reg_code_t                    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_targets_q <= MT_W'(1);
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      origin_z_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_TARGETS: max_targets_q <= pwdata[MT_W-1:0];
        REG_ORIGIN_X:    origin_x_q    <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:    origin_y_q    <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Z:    origin_z_q    <= pwdata[COORD_BITS-1:0];
      endcase
    end
  end

  // origins read back sign extended
  always_comb begin
    unique case (reg_sel)
      REG_MAX_TARGETS: prdata = APB_DW'(max_targets_q);
      REG_ORIGIN_X:    prdata = APB_DW'(origin_x_q);
      REG_ORIGIN_Y:    prdata = APB_DW'(origin_y_q);
      REG_ORIGIN_Z:    prdata = APB_DW'(origin_z_q);
    endcase
  end

  assign max_targets_o = max_targets_q;
  assign origin_x_o    = origin_x_q;
  assign origin_y_o    = origin_y_q;
  assign origin_z_o    = origin_z_q;

endmodule

@@ rtl/core/ckps_datapath.sv @@
// ckps_datapath: point stores, distance unit, distance store, min search, output register
// depends on ckps_pkg for cmd_t, status_t and widths
`timescale 1ns / 1ps

module ckps_datapath #(
  parameter int MAX_POINTS = ckps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = ckps_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ckps_pkg::cmd_t                   cmd_i,
  output ckps_pkg::status_t                status_o,
  input  logic [ckps_pkg::MT_W-1:0]        max_targets_i,
  input  logic signed [COORD_BITS-1:0]     origin_x_i,
  input  logic signed [COORD_BITS-1:0]     origin_y_i,
  input  logic signed [COORD_BITS-1:0]     origin_z_i,
  input  logic signed [COORD_BITS-1:0]     pos_x_i,
  input  logic signed [COORD_BITS-1:0]     pos_y_i,
  input  logic signed [COORD_BITS-1:0]     pos_z_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [ckps_pkg::IDX_OUT_W-1:0]   res_index_o,
  output logic [ckps_pkg::DIST_W-1:0]      res_dist_o,
  output logic                             res_last_o,
  output logic                             res_overflow_o
);
  import ckps_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (CW > MT_W) ? CW : MT_W;
  localparam int DW   = COORD_BITS + 1;

  // stores
  logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_z [MAX_POINTS];
  logic [DIST_W-1:0]            dist_mem [MAX_POINTS];

  // control registers
  logic [CW-1:0]   count_q, count_d;
  logic            overflow_q, overflow_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [MT_W-1:0] k_q, k_d;
  logic            scan_v_q;
  logic            found_q, found_d;
  logic            have_prev_q, have_prev_d;
  logic            res_valid_q, res_valid_d;

  // payload registers
  logic signed [COORD_BITS-1:0] crd_x_q, crd_y_q, crd_z_q;
  logic [SQ_IN_W-1:0]           mag_q;
  logic                         sat_q;
  logic [DIST_W-1:0]            prod_q;
  logic [DIST_W-1:0]            acc_q;
  logic [DIST_W-1:0]            dist_rd_q;
  logic [IW-1:0]                rd_idx_q;
  logic [DIST_W-1:0]            best_d_q;
  logic [IW-1:0]                best_i_q;
  logic [DIST_W-1:0]            prev_d_q;
  logic [IW-1:0]                prev_i_q;
  logic [IDX_OUT_W-1:0]         res_index_q;
  logic [DIST_W-1:0]            res_dist_q;
  logic                         res_last_q;
  logic                         res_overflow_q;

  // combinational
  logic signed [COORD_BITS-1:0] coord_sel, orig_sel;
  logic signed [DW-1:0]         diff;
  logic [DW-1:0]                mag;
  logic [MAG_EXT_W-1:0]         mag_ext;
  logic [DIST_W-1:0]            square;
  logic [DIST_W:0]              sum;
  logic [DIST_W-1:0]            sum_sat;
  logic                         store_room;
  logic                         is_cand;
  logic                         is_better;

  assign store_room = count_q < CW'(MAX_POINTS);

  // ---- point store, written while loading
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_room) begin
      mem_x[count_q[IW-1:0]] <= pos_x_i;
      mem_y[count_q[IW-1:0]] <= pos_y_i;
      mem_z[count_q[IW-1:0]] <= pos_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.crd) begin
      crd_x_q <= mem_x[idx_q];
      crd_y_q <= mem_y[idx_q];
      crd_z_q <= mem_z[idx_q];
    end
  end

  // ---- distance unit: magnitude, square, saturating accumulate
  always_comb begin
    unique case (cmd_i.axis)
      AXIS_X: begin coord_sel = crd_x_q; orig_sel = origin_x_i; end
      AXIS_Y: begin coord_sel = crd_y_q; orig_sel = origin_y_i; end
      AXIS_Z: begin coord_sel = crd_z_q; orig_sel = origin_z_i; end
      default: begin coord_sel = crd_x_q; orig_sel = origin_x_i; end
    endcase
  end

  assign diff    = DW'(coord_sel) - DW'(orig_sel);
  assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign mag_ext = MAG_EXT_W'(mag);
  assign square  = DIST_W'(mag_q) * DIST_W'(mag_q);
  assign sum     = {1'b0, acc_q} + {1'b0, prod_q};
  assign sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) begin
      mag_q <= mag_ext[SQ_IN_W-1:0];
      sat_q <= |mag_ext[MAG_EXT_W-1:SQ_IN_W];
    end
    if (cmd_i.mul) begin
      prod_q <= sat_q ? DIST_MAX : square;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc) begin
      acc_q <= sum_sat;
    end
  end

  // ---- distance store
  always_ff @(posedge clk_i) begin
    if (cmd_i.dwr) begin
      dist_mem[idx_q] <= acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drd) begin
      dist_rd_q <= dist_mem[idx_q];
      rd_idx_q  <= idx_q;
    end
  end

  // ---- min search: smallest (distance, index) above the previous pick
  assign is_cand = !have_prev_q || (dist_rd_q > prev_d_q) ||
                   ((dist_rd_q == prev_d_q) && (rd_idx_q > prev_i_q));
  assign is_better = !found_q || (dist_rd_q < best_d_q);

  always_ff @(posedge clk_i) begin
    if (scan_v_q && is_cand && is_better) begin
      best_d_q <= dist_rd_q;
      best_i_q <= rd_idx_q;
    end
    if (cmd_i.emit && cmd_i.emit_sel == EMIT_BEST) begin
      prev_d_q <= best_d_q;
      prev_i_q <= best_i_q;
    end
  end

  // ---- control state
  always_comb begin
    count_d     = count_q;
    overflow_d  = overflow_q;
    idx_d       = idx_q;
    k_d         = k_q;
    found_d     = found_q;
    have_prev_d = have_prev_q;
    res_valid_d = res_valid_q;

    if (cmd_i.store) begin
      if (store_room) begin
        count_d = count_q + CW'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
    if (cmd_i.best_clr) begin
      found_d = 1'b0;
    end else if (scan_v_q && is_cand) begin
      found_d = 1'b1;
    end
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      res_valid_d = 1'b1;
      if (cmd_i.emit_sel == EMIT_BEST) begin
        have_prev_d = 1'b1;
        k_d         = k_q + MT_W'(1);
      end
    end
    if (cmd_i.clear) begin
      count_d     = '0;
      overflow_d  = 1'b0;
      k_d         = '0;
      have_prev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      scan_v_q    <= 1'b0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      scan_v_q    <= cmd_i.scan;
      found_q     <= found_d;
      have_prev_q <= have_prev_d;
      res_valid_q <= res_valid_d;
    end
  end

  // ---- output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.emit_sel)
        EMIT_READ: begin
          res_index_q <= IDX_OUT_W'(rd_idx_q);
          res_dist_q  <= dist_rd_q;
        end
        EMIT_BEST: begin
          res_index_q <= IDX_OUT_W'(best_i_q);
          res_dist_q  <= best_d_q;
        end
      endcase
      res_last_q     <= cmd_i.emit_last;
      res_overflow_q <= overflow_q;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_index_o    = res_index_q;
  assign res_dist_o     = res_dist_q;
  assign res_last_o     = res_last_q;
  assign res_overflow_o = res_overflow_q;

  // ---- status
  assign status_o.idx_last  = (CW'(idx_q) == (count_q - CW'(1)));
  assign status_o.mode_all  = (CMPW'(max_targets_i) >= CMPW'(count_q));
  assign status_o.want_zero = (max_targets_i == '0);
  assign status_o.k_last    = (k_q == (max_targets_i - MT_W'(1)));
  assign status_o.out_free  = !res_valid_q || res_ready_i;

endmodule

@@ rtl/core/ckps_ctrl.sv @@
// ckps_ctrl: sequencer for loading, distance pass, in-order report and min-search passes
// depends on ckps_pkg for cmd_t and status_t
`timescale 1ns / 1ps

module ckps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pt_valid_i,
  input  logic                pt_last_i,
  output logic                pt_ready_o,
  input  ckps_pkg::status_t   status_i,
  output ckps_pkg::cmd_t      cmd_o
);
  import ckps_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_DRD    = 4'd1;
  localparam logic [3:0] S_DMX    = 4'd2;
  localparam logic [3:0] S_DMY    = 4'd3;
  localparam logic [3:0] S_DMZ    = 4'd4;
  localparam logic [3:0] S_DPZ    = 4'd5;
  localparam logic [3:0] S_DAZ    = 4'd6;
  localparam logic [3:0] S_DWR    = 4'd7;
  localparam logic [3:0] S_ERD    = 4'd8;
  localparam logic [3:0] S_EOUT   = 4'd9;
  localparam logic [3:0] S_PSTART = 4'd10;
  localparam logic [3:0] S_PSCAN  = 4'd11;
  localparam logic [3:0] S_PLAST  = 4'd12;
  localparam logic [3:0] S_POUT   = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    pt_ready_o = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        pt_ready_o = 1'b1;
        if (pt_valid_i) begin
          cmd_o.store = 1'b1;
          if (pt_last_i) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_DRD;
          end
        end
      end
      // distance pass, one point per round
      S_DRD: begin
        cmd_o.crd = 1'b1;
        state_d   = S_DMX;
      end
      S_DMX: begin
        cmd_o.mag  = 1'b1;
        cmd_o.axis = AXIS_X;
        state_d    = S_DMY;
      end
      S_DMY: begin
        cmd_o.mag  = 1'b1;
        cmd_o.axis = AXIS_Y;
        cmd_o.mul  = 1'b1;
        state_d    = S_DMZ;
      end
      S_DMZ: begin
        cmd_o.mag     = 1'b1;
        cmd_o.axis    = AXIS_Z;
        cmd_o.mul     = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_DPZ;
      end
      S_DPZ: begin
        cmd_o.mul = 1'b1;
        cmd_o.acc = 1'b1;
        state_d   = S_DAZ;
      end
      S_DAZ: begin
        cmd_o.acc = 1'b1;
        state_d   = S_DWR;
      end
      S_DWR: begin
        cmd_o.dwr = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          if (status_i.mode_all) begin
            state_d = S_ERD;
          end else if (status_i.want_zero) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            state_d = S_PSTART;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_DRD;
        end
      end
      // every point in load order
      S_ERD: begin
        cmd_o.drd = 1'b1;
        state_d   = S_EOUT;
      end
      S_EOUT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_READ;
          cmd_o.emit_last = status_i.idx_last;
          if (status_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_ERD;
          end
        end
      end
      // one min-search pass per reported point
      S_PSTART: begin
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d        = S_PSCAN;
      end
      S_PSCAN: begin
        cmd_o.drd  = 1'b1;
        cmd_o.scan = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_PLAST;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_PLAST: begin
        state_d = S_POUT;
      end
      S_POUT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_BEST;
          cmd_o.emit_last = status_i.k_last;
          if (status_i.k_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            state_d = S_PSTART;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
